// ----- rtl/action_change_timestamp_table_defines.svh -----
// Assertion helpers used by the checker file.
`ifndef ACTION_CHANGE_TIMESTAMP_TABLE_DEFINES_SVH
`define ACTION_CHANGE_TIMESTAMP_TABLE_DEFINES_SVH

// Concurrent assertion on clk, muted while rst is high.
`define ACTCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies a property in the next cycle.
`define ACTCT_ASSERT_NEXT(lbl, cond, prop, msg) \
  `ACTCT_ASSERT(lbl, (cond) |=> (prop), msg)

`endif

// ----- rtl/actct_pkg.sv -----
package actct_pkg;

  localparam int KEY_W      = 64;
  localparam int TICK_W     = 64;
  localparam int FREQ_W     = 32;
  localparam int TIME_W     = 32;
  localparam int FRAC_BITS  = 16;
  // elapsed * 2^16 / freq reaches 2^31 exactly when elapsed >> 15 >= freq
  localparam int OVF_SHIFT  = TIME_W - 1 - FRAC_BITS;
  localparam int DIV_STEPS  = TIME_W - 1;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd10000000;
  localparam logic [TIME_W-1:0] TIME_SAT   = 32'h8000_0000;

  // Input stream layout
  localparam int I_ACTION  = 0;
  localparam int I_ORIGIN  = I_ACTION + KEY_W;
  localparam int I_ACTIVE  = I_ORIGIN + KEY_W;
  localparam int I_STATE   = I_ACTIVE + 1;
  localparam int I_CHG     = I_STATE + 1;
  localparam int I_NOW     = I_CHG + 1;
  localparam int IN_USED   = I_NOW + TICK_W;
  localparam int IN_W      = ((IN_USED + 7) / 8) * 8;

  // Output stream layout
  localparam int O_CHANGED = 0;
  localparam int O_WRITTEN = 1;
  localparam int O_TIME    = 2;
  localparam int O_INS     = O_TIME + TIME_W;
  localparam int O_FULL    = O_INS + 1;
  localparam int OUT_USED  = O_FULL + 1;
  localparam int OUT_W     = ((OUT_USED + 7) / 8) * 8;

  typedef struct packed {
    logic [KEY_W-1:0]  action;
    logic [KEY_W-1:0]  origin;
    logic              last_state;
    logic [TICK_W-1:0] change_tick;
  } entry_t;

  typedef struct packed {
    logic              start;
    logic [TICK_W-1:0] elapsed;
    logic [FREQ_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [TIME_W-1:0] q_time;
  } div_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/actct_mem.sv -----
module actct_mem import actct_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  entry_t           wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/actct_div.sv -----
module actct_div import actct_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                     busy;
  logic                     done;
  logic [STEP_W-1:0]        step_cnt;
  logic [FREQ_W-1:0]        rem;
  logic [FREQ_W-1:0]        dvs;
  logic [DIV_STEPS-1:0]     sh;
  logic [DIV_STEPS-2:0]     quo;
  logic signed [TIME_W-1:0] result;

  logic [FREQ_W:0]   trial;
  logic [FREQ_W-1:0] diff;
  logic              ge;
  logic              ovf;
  logic [TIME_W-1:0] mag;

  assign trial = {rem, sh[DIV_STEPS-1]};
  // rem stays below dvs, so the difference fits in FREQ_W bits when ge is set
  assign diff  = trial[FREQ_W-1:0] - dvs;
  assign ge    = (trial >= {1'b0, dvs});
  assign mag   = {1'b0, quo, ge};
  assign ovf   = (req.divisor == '0) ||
                 (req.elapsed[TICK_W-1:OVF_SHIFT] >= (TICK_W-OVF_SHIFT)'(req.divisor));

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy     <= !ovf;
        done     <= ovf;
        step_cnt <= '0;
      end else if (busy) begin
        step_cnt <= step_cnt + 1'b1;
        if (step_cnt == STEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: one restoring step per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvs    <= req.divisor;
      rem    <= req.elapsed[OVF_SHIFT +: FREQ_W];
      sh     <= {req.elapsed[OVF_SHIFT-1:0], FRAC_BITS'(0)};
      result <= TIME_SAT;
    end else if (busy) begin
      rem <= ge ? diff : trial[FREQ_W-1:0];
      quo <= {quo[DIV_STEPS-3:0], ge};
      sh  <= {sh[DIV_STEPS-2:0], 1'b0};
      if (step_cnt == STEP_W'(DIV_STEPS - 1)) begin
        result <= TIME_W'(0) - mag;
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.q_time = result;

endmodule

// ----- rtl/action_change_timestamp_table.sv -----
// Flow: an inactive report goes straight to the done state and then to the output register;
// an active one first scans the table and, on a same-state hit with a nonzero stamp, divides.
// One report at a time: the next is accepted only back in idle, after the one-read-per-cycle
// table scan, the bit-serial 31-step divider and the output hand-off.
// Reset: clears the entry count, the control state and the output valid, and loads
// tick_frequency with 10000000; table contents stay undefined and are never read unwritten.
module action_change_timestamp_table import actct_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // action_key[63:0], origin_key[127:64], active[128], reported_state[129],
  // changed_in[130], now_ticks[194:131], zero pad[199:195]
  input  logic [IN_W-1:0]   s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // changed[0], time_written[1], update_time[33:2], inserted[34],
  // table_full[35], zero pad[39:36]
  output logic [OUT_W-1:0]  m_axis_tdata,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [FREQ_W-1:0] cfg_data
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Input fields
  logic [KEY_W-1:0]  in_action;
  logic [KEY_W-1:0]  in_origin;
  logic              in_active;
  logic              in_state;
  logic              in_chg;
  logic [TICK_W-1:0] in_now;

  assign in_action = s_axis_tdata[I_ACTION +: KEY_W];
  assign in_origin = s_axis_tdata[I_ORIGIN +: KEY_W];
  assign in_active = s_axis_tdata[I_ACTIVE];
  assign in_state  = s_axis_tdata[I_STATE];
  assign in_chg    = s_axis_tdata[I_CHG];
  assign in_now    = s_axis_tdata[I_NOW +: TICK_W];

  // Held report
  logic [KEY_W-1:0]  req_action;
  logic [KEY_W-1:0]  req_origin;
  logic              req_state;
  logic [TICK_W-1:0] req_now;

  // Control state
  state_t            state, state_next;
  logic [CNT_W-1:0]  entry_count, entry_count_next;
  logic [FREQ_W-1:0] tick_freq;
  logic [CNT_W-1:0]  scan_cnt, scan_cnt_next;
  logic              cmp_valid, cmp_valid_next;
  logic [IDX_W-1:0]  cmp_idx, cmp_idx_next;

  // Result under construction
  logic              res_changed, res_changed_next;
  logic              res_written, res_written_next;
  logic [TIME_W-1:0] res_time, res_time_next;
  logic              res_inserted, res_inserted_next;
  logic              res_full, res_full_next;

  // Output register
  logic              m_valid, m_valid_next;
  logic [OUT_W-1:0]  m_data;
  logic              m_load;

  // Table memory and divider
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic              mem_re;
  entry_t            mem_rdata;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic              s_xfer;
  logic              hit;
  logic              state_diff;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_data;

  assign hit        = cmp_valid && (mem_rdata.action == req_action) &&
                      (mem_rdata.origin == req_origin);
  assign state_diff = (mem_rdata.last_state != req_state);

  // Every write lands in the last scan cycle of a report and the next report
  // passes through the done and idle states before its first read, so read and write never meet
  // on one entry in the same cycle.
  actct_mem #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (scan_cnt[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  actct_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    state_next        = state;
    entry_count_next  = entry_count;
    scan_cnt_next     = scan_cnt;
    cmp_valid_next    = 1'b0;
    cmp_idx_next      = cmp_idx;
    res_changed_next  = res_changed;
    res_written_next  = res_written;
    res_time_next     = res_time;
    res_inserted_next = res_inserted;
    res_full_next     = res_full;
    m_load            = 1'b0;
    mem_we            = 1'b0;
    mem_waddr         = cmp_idx;
    mem_wdata         = '{action: req_action, origin: req_origin,
                          last_state: req_state, change_tick: req_now};
    mem_re            = 1'b0;
    div_req.start     = 1'b0;
    div_req.elapsed   = req_now - mem_rdata.change_tick;
    div_req.divisor   = tick_freq;

    case (state)
      ST_IDLE: begin
        if (s_xfer) begin
          // Default result: pass the report on untouched
          res_changed_next  = in_chg;
          res_written_next  = 1'b0;
          res_time_next     = '0;
          res_inserted_next = 1'b0;
          res_full_next     = 1'b0;
          scan_cnt_next     = '0;
          state_next        = in_active ? ST_SCAN : ST_DONE;
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle and compare the entry read the cycle before
        mem_re         = (scan_cnt < entry_count);
        cmp_valid_next = mem_re;
        cmp_idx_next   = scan_cnt[IDX_W-1:0];
        scan_cnt_next  = scan_cnt + CNT_W'(mem_re);
        if (hit) begin
          res_changed_next = state_diff;
          if (state_diff) begin
            // New state: restamp the entry, elapsed time is zero and only a
            // zero frequency with a nonzero now_ticks saturates it
            mem_we           = 1'b1;
            res_written_next = (req_now != '0);
            res_time_next    = ((req_now != '0) && (tick_freq == '0)) ? TIME_SAT : '0;
            state_next       = ST_DONE;
          end else if (mem_rdata.change_tick != '0) begin
            res_written_next = 1'b1;
            div_req.start    = 1'b1;
            state_next       = ST_DIV;
          end else begin
            state_next = ST_DONE;
          end
        end else if (!cmp_valid && (scan_cnt == entry_count)) begin
          // Miss: append a new entry unless the table is full
          if (entry_count == CNT_W'(TABLE_DEPTH)) begin
            res_full_next = 1'b1;
          end else begin
            mem_we            = 1'b1;
            mem_waddr         = entry_count[IDX_W-1:0];
            entry_count_next  = entry_count + 1'b1;
            res_inserted_next = 1'b1;
          end
          state_next = ST_DONE;
        end
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          res_time_next = div_rsp.q_time;
          state_next    = ST_DONE;
        end
      end

      ST_DONE: begin
        // Hand the result to the output register once it is free
        if (!m_valid || m_axis_tready) begin
          m_load     = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (m_load) begin
      m_valid_next = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_next = 1'b0;
    end else begin
      m_valid_next = m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      tick_freq   <= FREQ_RESET;
      scan_cnt    <= '0;
      cmp_valid   <= 1'b0;
      m_valid     <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
      scan_cnt    <= scan_cnt_next;
      cmp_valid   <= cmp_valid_next;
      m_valid     <= m_valid_next;
      if (cfg_valid && cfg_ready) begin
        tick_freq <= cfg_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmp_idx      <= cmp_idx_next;
    res_changed  <= res_changed_next;
    res_written  <= res_written_next;
    res_time     <= res_time_next;
    res_inserted <= res_inserted_next;
    res_full     <= res_full_next;
    if (s_xfer) begin
      req_action <= in_action;
      req_origin <= in_origin;
      req_state  <= in_state;
      req_now    <= in_now;
    end
    if (m_load) begin
      m_data <= {(OUT_W-OUT_USED)'(0), res_full, res_inserted, res_time,
                 res_written, res_changed};
    end
  end

endmodule

// ----- rtl/actct_chk.sv -----
`include "action_change_timestamp_table_defines.svh"

module actct_chk import actct_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  `ACTCT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output transfer dropped while stalled")
  `ACTCT_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "output data moved while stalled")
  `ACTCT_ASSERT(a_time_zero, m_axis_tvalid && !m_axis_tdata[O_WRITTEN] |-> m_axis_tdata[O_TIME +: TIME_W] == '0, "update_time set without time_written")
  `ACTCT_ASSERT(a_ins_excl, m_axis_tvalid && m_axis_tdata[O_INS] |-> !m_axis_tdata[O_FULL] && !m_axis_tdata[O_WRITTEN], "inserted with table_full or time_written")

endmodule

bind action_change_timestamp_table actct_chk u_actct_chk (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
